/* src/tfse_pkg.sv */
package tfse_pkg;

   // Configuration register indexes (byte address is four times the index).
   localparam logic [2:0] REG_FRICTION_RATE       = 3'd0;
   localparam logic [2:0] REG_STIFFNESS_RATE      = 3'd1;
   localparam logic [2:0] REG_STRAIGHT_GATE       = 3'd2;
   localparam logic [2:0] REG_CURVATURE_THRESHOLD = 3'd3;
   localparam logic [2:0] REG_FRICTION_NOMINAL    = 3'd4;
   localparam logic [2:0] REG_FRONT_NOMINAL       = 3'd5;
   localparam logic [2:0] REG_REAR_NOMINAL        = 3'd6;

   // Register reset values.
   localparam logic [15:0] FRICTION_RATE_RST   = 16'd66;
   localparam logic [15:0] STIFFNESS_RATE_RST  = 16'd66;
   localparam logic        STRAIGHT_GATE_RST   = 1'b1;
   localparam logic [15:0] CURV_THRESHOLD_RST  = 16'd41;
   localparam logic [13:0] FRICTION_NOM_RST    = 14'd4096;
   localparam logic [15:0] FRONT_NOM_RST       = 16'd15000;
   localparam logic [15:0] REAR_NOM_RST        = 16'd15000;

   // Speed above 0.1 m/s means vx^2 + vy^2 (Q8.8 squared) above 655.
   localparam logic [31:0] SPEED_SQ_MIN        = 32'd655;
   // Friction measurement: (|a| * 409600 + 490) / 981. The scale splits into
   // 417 * 981 + 523, so the quotient is |a| * 417 plus (|a| * 523 + 490) / 981.
   // The second part stays below 2^25 and is divided by multiplying with
   // ceil(2^35 / 981) and keeping the bits from 35 up, which is exact there.
   localparam logic [8:0]  MEAS_WHOLE          = 9'd417;
   localparam logic [9:0]  MEAS_PART           = 10'd523;
   localparam logic [24:0] MEAS_ROUND          = 25'd490;
   localparam logic [25:0] MEAS_RECIP          = 26'd35025218;
   localparam logic [21:0] MEAS_MIN            = 22'd52429;
   localparam logic [21:0] MEAS_MAX            = 22'd2621440;
   // Friction ratio limits in Q.16, and the nominal below which 0.1 is used.
   localparam logic [17:0] RATIO_MIN           = 18'd13107;
   localparam logic [17:0] RATIO_MAX           = 18'd131072;
   localparam logic [13:0] NOMINAL_FLOOR       = 14'd410;

   // Divider runs one quotient bit per cycle over a 34-bit dividend.
   localparam int          DIV_BITS            = 34;
   localparam logic [5:0]  DIV_LAST            = 6'(DIV_BITS - 1);

   // Sequencer states, one-hot.
   typedef enum logic [22:0] {
      ST_IDLE  = 23'h000001,
      ST_VX    = 23'h000002,
      ST_VY    = 23'h000004,
      ST_YAW   = 23'h000008,
      ST_TH    = 23'h000010,
      ST_THS   = 23'h000020,
      ST_GATE  = 23'h000040,
      ST_MREC  = 23'h000080,
      ST_MINT  = 23'h000100,
      ST_DIV   = 23'h000200,
      ST_FB1   = 23'h000400,
      ST_FB2   = 23'h000800,
      ST_FB3   = 23'h001000,
      ST_RATIO = 23'h002000,
      ST_RATQ  = 23'h004000,
      ST_TF    = 23'h008000,
      ST_TR    = 23'h010000,
      ST_F1    = 23'h020000,
      ST_F2    = 23'h040000,
      ST_F3    = 23'h080000,
      ST_R2    = 23'h100000,
      ST_R3    = 23'h200000,
      ST_OUT   = 23'h400000
   } state_type;

   // Magnitude of a signed 16-bit value; the most negative value gives 32768.
   function automatic logic [16:0] mag16(input logic [15:0] x);
      logic [16:0] e;
      e = {x[15], x};
      return x[15] ? (~e + 17'd1) : e;
   endfunction

   // Clamp the friction measurement to 0.05 .. 2.5 in Q2.20.
   function automatic logic [21:0] clamp_meas(input logic [33:0] q);
      logic [21:0] r;
      if (q < 34'(MEAS_MIN)) begin
         r = MEAS_MIN;
      end else if (q > 34'(MEAS_MAX)) begin
         r = MEAS_MAX;
      end else begin
         r = q[21:0];
      end
      return r;
   endfunction

   // Clamp the friction ratio to 0.2 .. 2.0 in Q.16.
   function automatic logic [17:0] clamp_ratio(input logic [33:0] q);
      logic [17:0] r;
      if (q < 34'(RATIO_MIN)) begin
         r = RATIO_MIN;
      end else if (q > 34'(RATIO_MAX)) begin
         r = RATIO_MAX;
      end else begin
         r = q[17:0];
      end
      return r;
   endfunction

endpackage

/* src/tire_friction_stiffness_estimator.sv */
// Tire friction and cornering stiffness estimator.
//
// Input beats arrive on req_* (one per sensor tick) carrying velocities, yaw
// rate and lateral acceleration. Each beat yields exactly one result beat on
// rsp_*: the friction estimate, both stiffness estimates and an updated flag
// in rsp_tuser that is low when the low-curvature gate skipped the update.
// The csr_* port holds the tuning registers; writing a nominal register also
// reloads the matching estimate. Write registers only while the block is idle.
//
// One 32x32 multiplier is shared under a sequencer, next to one radix-2 divider
// (one quotient bit per cycle) for the friction ratio, so one beat is worked on
// at a time and req_tready is high only in the idle state. A gated beat skips
// the measurement and blends, a friction nominal below 0.1 skips the ratio
// division, and otherwise that division dominates the path to result valid.
// A new beat can be taken in the cycle after its result is registered.
// Reset restores the tuning registers and estimates to their defaults. If the
// receiver stalls, the result waits in the output register, and the next
// finished result waits in the sequencer until that register is free.
module tire_friction_stiffness_estimator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // vel_long[15:0], vel_lat[31:16], yaw[47:32], lat_accel[63:48]
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // friction[13:0], front_stiffness[30:14], rear_stiffness[47:31]
   output logic [47:0] rsp_tdata,
   // updated[0]
   output logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tfse_pkg::*;

   state_type   state_ff, state_in;

   // Configuration registers.
   logic [15:0] friction_rate_ff, friction_rate_in;
   logic [15:0] stiffness_rate_ff, stiffness_rate_in;
   logic        gate_enable_ff, gate_enable_in;
   logic [15:0] threshold_ff, threshold_in;
   logic [13:0] friction_nom_ff, friction_nom_in;
   logic [15:0] front_nom_ff, front_nom_in;
   logic [15:0] rear_nom_ff, rear_nom_in;

   // Estimates.
   logic [23:0] fest_ff, fest_in;
   logic [31:0] front_est_ff, front_est_in;
   logic [31:0] rear_est_ff, rear_est_in;

   // Working registers of the sequencer.
   logic [16:0] vx_ff, vx_in;
   logic [16:0] vy_ff, vy_in;
   logic [16:0] yaw_ff, yaw_in;
   logic [16:0] accel_ff, accel_in;
   logic [31:0] sumsq_ff, sumsq_in;
   logic [46:0] lhs_ff, lhs_in;
   logic [63:0] prod_ff, prod_in;
   logic [47:0] sum_ff, sum_in;
   logic [21:0] meas_ff, meas_in;
   logic [17:0] ratio_ff, ratio_in;
   logic [31:0] tf_ff, tf_in;
   logic [31:0] tr_ff, tr_in;
   logic        upd_ff, upd_in;

   // Divider registers.
   logic [14:0] div_rem_ff, div_rem_in;
   logic [33:0] div_quo_ff, div_quo_in;
   logic [14:0] div_den_ff, div_den_in;
   logic [5:0]  div_cnt_ff, div_cnt_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic        rsp_user_ff, rsp_user_in;

   // Combinational helpers.
   logic [31:0] mul_a, mul_b;
   logic        csr_wr;
   logic [2:0]  csr_idx;
   logic [15:0] div_shl, div_diff;
   logic        div_ge;
   logic [48:0] blend_sum;
   logic [32:0] tgt_round;
   logic [24:0] fric_round;
   logic [27:0] small_ratio;
   logic        speed_ok, below;

   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   // Register read mux.
   always_comb begin
      case (csr_idx)
         REG_FRICTION_RATE:       csr_prdata = {16'd0, friction_rate_ff};
         REG_STIFFNESS_RATE:      csr_prdata = {16'd0, stiffness_rate_ff};
         REG_STRAIGHT_GATE:       csr_prdata = {31'd0, gate_enable_ff};
         REG_CURVATURE_THRESHOLD: csr_prdata = {16'd0, threshold_ff};
         REG_FRICTION_NOMINAL:    csr_prdata = {18'd0, friction_nom_ff};
         REG_FRONT_NOMINAL:       csr_prdata = {16'd0, front_nom_ff};
         REG_REAR_NOMINAL:        csr_prdata = {16'd0, rear_nom_ff};
         default:                 csr_prdata = 32'd0;
      endcase
   end

   // Shared multiplier with a registered product.
   assign prod_in = {32'd0, mul_a} * {32'd0, mul_b};

   // One restoring division step.
   assign div_shl  = {div_rem_ff, div_quo_ff[33]};
   assign div_ge   = div_shl >= {1'b0, div_den_ff};
   assign div_diff = div_shl - {1'b0, div_den_ff};

   // Blend adder: previous product plus current product, rounded.
   assign blend_sum = {1'b0, sum_ff} + {1'b0, prod_ff[47:0]} + 49'd32768;

   // Stiffness target rounding: (nominal * ratio + 1) >> 1.
   assign tgt_round = prod_ff[32:0] + 33'd1;

   // Friction output rounding from Q4.20 to Q2.12.
   assign fric_round = {1'b0, fest_ff} + 25'd128;

   // Ratio for a tiny nominal: est * 10 / 16, rounded.
   assign small_ratio = ({4'd0, fest_ff} << 3) + ({4'd0, fest_ff} << 1) + 28'd8;

   // Gate decision from the squared quantities.
   assign speed_ok = sumsq_ff > SPEED_SQ_MIN;
   assign below    = speed_ok ? ({17'd0, lhs_ff} < prod_ff) : (threshold_ff != 16'd0);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Sequencer and register next values.
   always_comb begin
      state_in          = state_ff;
      friction_rate_in  = friction_rate_ff;
      stiffness_rate_in = stiffness_rate_ff;
      gate_enable_in    = gate_enable_ff;
      threshold_in      = threshold_ff;
      friction_nom_in   = friction_nom_ff;
      front_nom_in      = front_nom_ff;
      rear_nom_in       = rear_nom_ff;
      fest_in           = fest_ff;
      front_est_in      = front_est_ff;
      rear_est_in       = rear_est_ff;
      vx_in             = vx_ff;
      vy_in             = vy_ff;
      yaw_in            = yaw_ff;
      accel_in          = accel_ff;
      sumsq_in          = sumsq_ff;
      lhs_in            = lhs_ff;
      sum_in            = sum_ff;
      meas_in           = meas_ff;
      ratio_in          = ratio_ff;
      tf_in             = tf_ff;
      tr_in             = tr_ff;
      upd_in            = upd_ff;
      div_rem_in        = div_rem_ff;
      div_quo_in        = div_quo_ff;
      div_den_in        = div_den_ff;
      div_cnt_in        = div_cnt_ff;
      rsp_valid_in      = rsp_valid_ff & ~rsp_tready;
      rsp_data_in       = rsp_data_ff;
      rsp_user_in       = rsp_user_ff;
      mul_a             = 32'd0;
      mul_b             = 32'd0;

      // Register writes; nominal writes also reload the estimate.
      if (csr_wr) begin
         case (csr_idx)
            REG_FRICTION_RATE:       friction_rate_in  = csr_pwdata[15:0];
            REG_STIFFNESS_RATE:      stiffness_rate_in = csr_pwdata[15:0];
            REG_STRAIGHT_GATE:       gate_enable_in    = csr_pwdata[0];
            REG_CURVATURE_THRESHOLD: threshold_in      = csr_pwdata[15:0];
            REG_FRICTION_NOMINAL: begin
               friction_nom_in = csr_pwdata[13:0];
               fest_in         = {csr_pwdata[13:0], 8'd0};
            end
            REG_FRONT_NOMINAL: begin
               front_nom_in = csr_pwdata[15:0];
               front_est_in = {csr_pwdata[15:0], 15'd0};
            end
            REG_REAR_NOMINAL: begin
               rear_nom_in = csr_pwdata[15:0];
               rear_est_in = {csr_pwdata[15:0], 15'd0};
            end
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               vx_in    = mag16(req_tdata[15:0]);
               vy_in    = mag16(req_tdata[31:16]);
               yaw_in   = mag16(req_tdata[47:32]);
               accel_in = mag16(req_tdata[63:48]);
               state_in = ST_VX;
            end
         end
         // Squares for the speed and curvature gates.
         ST_VX: begin
            mul_a    = {15'd0, vx_ff};
            mul_b    = {15'd0, vx_ff};
            state_in = ST_VY;
         end
         ST_VY: begin
            sumsq_in = prod_ff[31:0];
            mul_a    = {15'd0, vy_ff};
            mul_b    = {15'd0, vy_ff};
            state_in = ST_YAW;
         end
         ST_YAW: begin
            sumsq_in = sumsq_ff + prod_ff[31:0];
            mul_a    = {15'd0, yaw_ff};
            mul_b    = {15'd0, yaw_ff};
            state_in = ST_TH;
         end
         ST_TH: begin
            lhs_in   = {prod_ff[30:0], 16'd0};
            mul_a    = {16'd0, threshold_ff};
            mul_b    = {16'd0, threshold_ff};
            state_in = ST_THS;
         end
         ST_THS: begin
            mul_a    = prod_ff[31:0];
            mul_b    = sumsq_ff;
            state_in = ST_GATE;
         end
         // Decide on the update and start the friction measurement.
         ST_GATE: begin
            upd_in   = ~(gate_enable_ff & below);
            mul_a    = {15'd0, accel_ff};
            mul_b    = {22'd0, MEAS_PART};
            state_in = (gate_enable_ff & below) ? ST_OUT : ST_MREC;
         end
         // Divide the remainder part by 981 through the reciprocal.
         ST_MREC: begin
            mul_a    = {7'd0, prod_ff[24:0] + MEAS_ROUND};
            mul_b    = {6'd0, MEAS_RECIP};
            state_in = ST_MINT;
         end
         ST_MINT: begin
            sum_in   = {32'd0, prod_ff[50:35]};
            mul_a    = {15'd0, accel_ff};
            mul_b    = {23'd0, MEAS_WHOLE};
            state_in = ST_FB1;
         end
         // Ratio divider, one quotient bit per cycle.
         ST_DIV: begin
            div_rem_in = div_ge ? div_diff[14:0] : div_shl[14:0];
            div_quo_in = {div_quo_ff[32:0], div_ge};
            div_cnt_in = div_cnt_ff - 6'd1;
            if (div_cnt_ff == 6'd0) begin
               state_in = ST_RATQ;
            end
         end
         // Friction blend.
         ST_FB1: begin
            meas_in  = clamp_meas(prod_ff[33:0] + sum_ff[33:0]);
            mul_a    = {8'd0, fest_ff};
            mul_b    = {15'd0, 17'h10000 - {1'b0, friction_rate_ff}};
            state_in = ST_FB2;
         end
         ST_FB2: begin
            sum_in   = prod_ff[47:0];
            mul_a    = {10'd0, meas_ff};
            mul_b    = {16'd0, friction_rate_ff};
            state_in = ST_FB3;
         end
         ST_FB3: begin
            fest_in  = blend_sum[39:16];
            state_in = ST_RATIO;
         end
         // Friction ratio against the nominal.
         ST_RATIO: begin
            if (friction_nom_ff >= NOMINAL_FLOOR) begin
               div_rem_in   = 15'd0;
               div_quo_in   = {1'b0, fest_ff, 9'd0} + {20'd0, friction_nom_ff};
               div_den_in   = {friction_nom_ff, 1'b0};
               div_cnt_in   = DIV_LAST;
               state_in     = ST_DIV;
            end else begin
               ratio_in = clamp_ratio({10'd0, small_ratio[27:4]});
               state_in = ST_TF;
            end
         end
         ST_RATQ: begin
            ratio_in = clamp_ratio(div_quo_ff);
            state_in = ST_TF;
         end
         // Stiffness targets and blends.
         ST_TF: begin
            mul_a    = {16'd0, front_nom_ff};
            mul_b    = {14'd0, ratio_ff};
            state_in = ST_TR;
         end
         ST_TR: begin
            tf_in    = tgt_round[32:1];
            mul_a    = {16'd0, rear_nom_ff};
            mul_b    = {14'd0, ratio_ff};
            state_in = ST_F1;
         end
         ST_F1: begin
            tr_in    = tgt_round[32:1];
            mul_a    = front_est_ff;
            mul_b    = {15'd0, 17'h10000 - {1'b0, stiffness_rate_ff}};
            state_in = ST_F2;
         end
         ST_F2: begin
            sum_in   = prod_ff[47:0];
            mul_a    = tf_ff;
            mul_b    = {16'd0, stiffness_rate_ff};
            state_in = ST_F3;
         end
         ST_F3: begin
            front_est_in = blend_sum[47:16];
            mul_a        = rear_est_ff;
            mul_b        = {15'd0, 17'h10000 - {1'b0, stiffness_rate_ff}};
            state_in     = ST_R2;
         end
         ST_R2: begin
            sum_in   = prod_ff[47:0];
            mul_a    = tr_ff;
            mul_b    = {16'd0, stiffness_rate_ff};
            state_in = ST_R3;
         end
         ST_R3: begin
            rear_est_in = blend_sum[47:16];
            state_in    = ST_OUT;
         end
         // Hand the result to the output register once it is free.
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {rear_est_ff[31:15], front_est_ff[31:15], fric_round[21:8]};
               rsp_user_in  = upd_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state and configuration, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         rsp_valid_ff      <= 1'b0;
         friction_rate_ff  <= FRICTION_RATE_RST;
         stiffness_rate_ff <= STIFFNESS_RATE_RST;
         gate_enable_ff    <= STRAIGHT_GATE_RST;
         threshold_ff      <= CURV_THRESHOLD_RST;
         friction_nom_ff   <= FRICTION_NOM_RST;
         front_nom_ff      <= FRONT_NOM_RST;
         rear_nom_ff       <= REAR_NOM_RST;
         fest_ff           <= {FRICTION_NOM_RST, 8'd0};
         front_est_ff      <= {FRONT_NOM_RST, 15'd0};
         rear_est_ff       <= {REAR_NOM_RST, 15'd0};
      end else begin
         state_ff          <= state_in;
         rsp_valid_ff      <= rsp_valid_in;
         friction_rate_ff  <= friction_rate_in;
         stiffness_rate_ff <= stiffness_rate_in;
         gate_enable_ff    <= gate_enable_in;
         threshold_ff      <= threshold_in;
         friction_nom_ff   <= friction_nom_in;
         front_nom_ff      <= front_nom_in;
         rear_nom_ff       <= rear_nom_in;
         fest_ff           <= fest_in;
         front_est_ff      <= front_est_in;
         rear_est_ff       <= rear_est_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      vx_ff        <= vx_in;
      vy_ff        <= vy_in;
      yaw_ff       <= yaw_in;
      accel_ff     <= accel_in;
      sumsq_ff     <= sumsq_in;
      lhs_ff       <= lhs_in;
      prod_ff      <= prod_in;
      sum_ff       <= sum_in;
      meas_ff      <= meas_in;
      ratio_ff     <= ratio_in;
      tf_ff        <= tf_in;
      tr_ff        <= tr_in;
      upd_ff       <= upd_in;
      div_rem_ff   <= div_rem_in;
      div_quo_ff   <= div_quo_in;
      div_den_ff   <= div_den_in;
      div_cnt_ff   <= div_cnt_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

endmodule
